>>> hdl/swm2_pkg.sv
// ----------------------------------------------------------------------------
// swm2_pkg
// Shared types, widths, register codes and size defaults for the
// two-dimensional sliding-window minimum filter.
// ----------------------------------------------------------------------------
package swm2_pkg;

    localparam int PIXEL_W          = 32;
    localparam int CFG_DATA_W       = 11;
    localparam int CFG_INDEX_W      = 2;
    localparam int WIN_REG_W        = 5;
    localparam int MAX_IMAGE_HEIGHT = 1024;
    localparam int ROW_W            = $clog2(MAX_IMAGE_HEIGHT);

    localparam int DEF_MAX_IMAGE_WIDTH   = 1024;
    localparam int DEF_MAX_WINDOW_HEIGHT = 16;
    localparam int DEF_MAX_WINDOW_WIDTH  = 16;

    typedef logic signed [PIXEL_W-1:0] pixel_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_WINDOW_WIDTH  = 2'd2,
        CFG_WINDOW_HEIGHT = 2'd3
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
    localparam logic [WIN_REG_W-1:0]  RST_WINDOW_WIDTH  = 5'd3;
    localparam logic [WIN_REG_W-1:0]  RST_WINDOW_HEIGHT = 5'd3;

    // largest positive pixel: neutral element of the minimum
    localparam pixel_t PIXEL_MAX = {1'b0, {(PIXEL_W-1){1'b1}}};

endpackage

>>> hdl/swm2_ifs.sv
// ----------------------------------------------------------------------------
// swm2 channel interfaces
// Valid/ready channels for pixels in, window minima out and register writes.
// ----------------------------------------------------------------------------
interface swm2_pixel_if import swm2_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface swm2_result_if import swm2_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t window_min;
    logic   row_end;
    logic   frame_end;

    modport source (output valid, output window_min, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input window_min, input row_end, input frame_end,
                    output ready);
endinterface

interface swm2_cfg_if import swm2_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/swm2_min_tree.sv
// ----------------------------------------------------------------------------
// swm2_min_tree
// Balanced tree of signed comparators; masked-off inputs drop out.
// ----------------------------------------------------------------------------
module swm2_min_tree
    import swm2_pkg::*;
#(
    parameter int N = 2
)(
    input  pixel_t         vals [N],
    input  logic [N-1:0]   use_mask,
    output pixel_t         min_val
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;
    localparam int P      = 1 << LEVELS;

    pixel_t work [P];

    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            work[i] = PIXEL_MAX;
        end
        for (int i = 0; i < N; i++)
        begin
            if (use_mask[i])
            begin
                work[i] = vals[i];
            end
        end
        // fold pairs level by level, in place
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < (P >> (l + 1)); i++)
            begin
                work[i] = (work[2*i+1] < work[2*i]) ? work[2*i+1] : work[2*i];
            end
        end
        min_val = work[0];
    end

endmodule

>>> hdl/sliding_window_min_2d_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_min_2d_unit
// Two-dimensional sliding-window minimum over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter one per transfer in raster order. For each pixel whose full
// window_height x window_width window lies inside the frame, one result
// transfer carries the signed minimum of that window, with row_end on the
// last result of each row and frame_end on the last of the frame. The unit
// takes one pixel per cycle while results are accepted. The transfer loads
// the pixel and the line-bank reads into stage A; the column minimum then
// moves into the column window of stage B, and the row minimum into the
// output register. The earlier rows live in MAX_WINDOW_HEIGHT-1 line banks
// of MAX_IMAGE_WIDTH words, one read and one write port each; there is no
// clearing pass after reset. Sizes are clamped to their legal ranges (zero
// reads as one). Write the size registers only while no pixel is in flight;
// positions wrap at each frame end.
// ----------------------------------------------------------------------------
module sliding_window_min_2d_unit
    import swm2_pkg::*;
#(
    parameter int MAX_IMAGE_WIDTH   = DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_WINDOW_HEIGHT = DEF_MAX_WINDOW_HEIGHT,
    parameter int MAX_WINDOW_WIDTH  = DEF_MAX_WINDOW_WIDTH
)(
    input  logic           clk,
    input  logic           rst_n,
    swm2_cfg_if.sink       cfg,
    swm2_pixel_if.sink     pixels,
    swm2_result_if.source  results
);

    localparam int COL_W     = $clog2(MAX_IMAGE_WIDTH);
    localparam int DIM_W     = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
    localparam int LINE_ROWS = MAX_WINDOW_HEIGHT - 1;
    localparam int SLOT_W    = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    // reciprocal of LINE_ROWS for the row-to-bank mapping of the last row
    localparam int RECIP_SH  = ROW_W + SLOT_W;
    localparam int RECIP     = (2**RECIP_SH + LINE_ROWS - 1) / LINE_ROWS;
    localparam int PROD_W    = ROW_W + RECIP_SH + 1;

    // Line bank of the last row for a height register value: the clamped
    // height minus one, modulo LINE_ROWS, by reciprocal multiplication.
    function automatic logic [SLOT_W-1:0] last_row_slot(logic [CFG_DATA_W-1:0] h_val);
        logic [ROW_W-1:0]  last;
        logic [PROD_W-1:0] prod;
        logic [ROW_W-1:0]  quot;
        logic [ROW_W-1:0]  rem;
        if (h_val == '0)
            last = '0;
        else if (DIM_W'(h_val) > DIM_W'(MAX_IMAGE_HEIGHT))
            last = ROW_W'(MAX_IMAGE_HEIGHT - 1);
        else
            last = ROW_W'(h_val - CFG_DATA_W'(1));
        prod = PROD_W'(last) * PROD_W'(RECIP);
        quot = ROW_W'(prod >> RECIP_SH);
        rem  = last - quot * ROW_W'(LINE_ROWS);
        return SLOT_W'(rem);
    endfunction

    // ------------------------------------------------------------------
    // Size registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] img_w_reg;
    logic [CFG_DATA_W-1:0] img_h_reg;
    logic [WIN_REG_W-1:0]  win_w_reg;
    logic [WIN_REG_W-1:0]  win_h_reg;
    logic [SLOT_W-1:0]     last_slot_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg     <= RST_IMAGE_WIDTH;
            img_h_reg     <= RST_IMAGE_HEIGHT;
            win_w_reg     <= RST_WINDOW_WIDTH;
            win_h_reg     <= RST_WINDOW_HEIGHT;
            last_slot_reg <= last_row_slot(RST_IMAGE_HEIGHT);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_IMAGE_WIDTH:   img_w_reg <= cfg.data;
                CFG_IMAGE_HEIGHT:
                begin
                    img_h_reg     <= cfg.data;
                    last_slot_reg <= last_row_slot(cfg.data);
                end
                CFG_WINDOW_WIDTH:  win_w_reg <= cfg.data[WIN_REG_W-1:0];
                CFG_WINDOW_HEIGHT: win_h_reg <= cfg.data[WIN_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp each size into its legal range; zero counts as one.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] ww_eff;
    logic [DIM_W-1:0] wh_eff;

    always_comb
    begin
        if (img_w_reg == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(img_w_reg) > DIM_W'(MAX_IMAGE_WIDTH))
            w_eff = DIM_W'(MAX_IMAGE_WIDTH);
        else
            w_eff = DIM_W'(img_w_reg);

        if (img_h_reg == '0)
            h_eff = DIM_W'(1);
        else if (DIM_W'(img_h_reg) > DIM_W'(MAX_IMAGE_HEIGHT))
            h_eff = DIM_W'(MAX_IMAGE_HEIGHT);
        else
            h_eff = DIM_W'(img_h_reg);

        if (win_w_reg == '0)
            ww_eff = DIM_W'(1);
        else if (DIM_W'(win_w_reg) > DIM_W'(MAX_WINDOW_WIDTH))
            ww_eff = DIM_W'(MAX_WINDOW_WIDTH);
        else
            ww_eff = DIM_W'(win_w_reg);

        if (win_h_reg == '0)
            wh_eff = DIM_W'(1);
        else if (DIM_W'(win_h_reg) > DIM_W'(MAX_WINDOW_HEIGHT))
            wh_eff = DIM_W'(MAX_WINDOW_HEIGHT);
        else
            wh_eff = DIM_W'(win_h_reg);
    end

    // ------------------------------------------------------------------
    // Handshake chain: input -> stage A -> stage B -> output register
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic b_emit_reg;
    logic out_valid_reg;
    logic out_free;
    logic b_leave;
    logic b_ready;
    logic a_leave;
    logic in_ready;
    logic pix_accept;

    assign out_free   = !out_valid_reg || results.ready;
    // a non-emitting item leaves stage B without touching the output
    assign b_leave    = b_valid_reg && (!b_emit_reg || out_free);
    assign b_ready    = !b_valid_reg || b_leave;
    assign a_leave    = a_valid_reg && b_ready;
    assign in_ready   = !a_valid_reg || a_leave;
    assign pix_accept = pixels.valid && in_ready;

    assign pixels.ready = in_ready;

    // ------------------------------------------------------------------
    // Position tracking
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  row_eff;
    logic [SLOT_W-1:0] slot_eff;
    logic              row_clamped;
    logic              last_col;
    logic              last_row;
    logic              row_full;
    logic              col_full;

    always_comb
    begin
        // a position beyond a shrunk size is taken as the last one
        row_clamped = (DIM_W'(row_reg) >= h_eff);
        col_eff  = (DIM_W'(col_reg) >= w_eff) ? COL_W'(w_eff - DIM_W'(1)) : col_reg;
        row_eff  = row_clamped ? ROW_W'(h_eff - DIM_W'(1)) : row_reg;
        // a clamped row maps to the line bank of the last row
        slot_eff = row_clamped ? last_slot_reg : slot_reg;
        last_col = (DIM_W'(col_eff) == w_eff - DIM_W'(1));
        last_row = (DIM_W'(row_eff) == h_eff - DIM_W'(1));
        row_full = (DIM_W'(row_eff) >= wh_eff - DIM_W'(1));
        col_full = (DIM_W'(col_eff) >= ww_eff - DIM_W'(1));

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (pix_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_eff + ROW_W'(1);
                    slot_next = (slot_reg == SLOT_W'(LINE_ROWS - 1)) ? '0
                                                                  : slot_reg + SLOT_W'(1);
                end
            end
            else
            begin
                col_next = col_eff + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Line banks: bank slot_eff takes the current row, the others hold
    // the earlier rows; the age of a bank picks whether it is in the window.
    // The current row's bank counts as the oldest: it is read before the
    // current pixel overwrites it.
    // ------------------------------------------------------------------
    logic [LINE_ROWS-1:0] bank_we;
    logic [LINE_ROWS-1:0] bank_use;
    pixel_t               bank_rd_reg [LINE_ROWS];

    always_comb
    begin
        logic [SLOT_W:0] age;
        for (int b = 0; b < LINE_ROWS; b++)
        begin
            if ((SLOT_W+1)'(slot_eff) > (SLOT_W+1)'(b))
                age = (SLOT_W+1)'(slot_eff) - (SLOT_W+1)'(b);
            else
                age = (SLOT_W+1)'(slot_eff) + (SLOT_W+1)'(LINE_ROWS) - (SLOT_W+1)'(b);
            bank_we[b]  = pix_accept && (slot_eff == SLOT_W'(b));
            bank_use[b] = row_full && (DIM_W'(age) < wh_eff);
        end
    end

    for (genvar b = 0; b < LINE_ROWS; b++)
    begin : g_bank
        pixel_t line_mem [MAX_IMAGE_WIDTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                line_mem[col_eff] <= pixels.pixel;
            if (pix_accept)
                bank_rd_reg[b] <= line_mem[col_eff];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: pixel plus bank reads -> column minimum
    // ------------------------------------------------------------------
    pixel_t               a_pixel_reg;
    logic [LINE_ROWS-1:0] a_use_reg;
    logic                 a_emit_reg;
    logic                 a_row_end_reg;
    logic                 a_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            a_pixel_reg     <= pixels.pixel;
            a_use_reg       <= bank_use;
            a_emit_reg      <= row_full && col_full;
            a_row_end_reg   <= last_col;
            a_frame_end_reg <= last_col && last_row;
        end
    end

    pixel_t                       col_vals [MAX_WINDOW_HEIGHT];
    logic [MAX_WINDOW_HEIGHT-1:0] col_mask;
    pixel_t                       col_min;

    always_comb
    begin
        col_vals[0] = a_pixel_reg;
        col_mask[0] = 1'b1;
        for (int b = 0; b < LINE_ROWS; b++)
        begin
            col_vals[b+1] = bank_rd_reg[b];
            col_mask[b+1] = a_use_reg[b];
        end
    end

    swm2_min_tree #(
        .N        (MAX_WINDOW_HEIGHT)
    ) u_col_tree (
        .vals     (col_vals),
        .use_mask (col_mask),
        .min_val  (col_min)
    );

    // ------------------------------------------------------------------
    // Stage B: column-minimum window -> row minimum
    // ------------------------------------------------------------------
    pixel_t col_win_reg [MAX_WINDOW_WIDTH];
    logic   b_row_end_reg;
    logic   b_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    // advance the window only when a real item moves in
    always_ff @(posedge clk)
    begin
        if (a_leave)
        begin
            col_win_reg[0] <= col_min;
            for (int k = 1; k < MAX_WINDOW_WIDTH; k++)
                col_win_reg[k] <= col_win_reg[k-1];
            b_emit_reg      <= a_emit_reg;
            b_row_end_reg   <= a_row_end_reg;
            b_frame_end_reg <= a_frame_end_reg;
        end
    end

    logic [MAX_WINDOW_WIDTH-1:0] win_use;
    pixel_t                      row_min;

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOW_WIDTH; k++)
            win_use[k] = (DIM_W'(k) < ww_eff);
    end

    swm2_min_tree #(
        .N        (MAX_WINDOW_WIDTH)
    ) u_row_tree (
        .vals     (col_win_reg),
        .use_mask (win_use),
        .min_val  (row_min)
    );

    // ------------------------------------------------------------------
    // Output register: hold until the transfer completes
    // ------------------------------------------------------------------
    pixel_t out_min_reg;
    logic   out_row_end_reg;
    logic   out_frame_end_reg;
    logic   out_valid_next;

    assign out_valid_next = out_free ? (b_valid_reg && b_emit_reg) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && b_valid_reg && b_emit_reg)
        begin
            out_min_reg       <= row_min;
            out_row_end_reg   <= b_row_end_reg;
            out_frame_end_reg <= b_frame_end_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.window_min = out_min_reg;
    assign results.row_end    = out_row_end_reg;
    assign results.frame_end  = out_frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // at most one line bank takes the current pixel
    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("more than one line bank written in one cycle");

    // a stalled item in stage A is not dropped
    a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_leave |=> a_valid_reg)
        else $error("stage A item lost while stalled");

    // an emitting item blocked by the output stays in stage B
    a_stage_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_emit_reg && !out_free |=> b_valid_reg && b_emit_reg)
        else $error("stage B result lost while output full");

    // the last result of a frame also closes its row
    a_frame_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_end |-> results.row_end)
        else $error("frame end without row end");

endmodule
